/* sv/sha1_pkg.sv */
// Shared types and constants for the SHA-1 message hash engine.
package sha1_pkg;

    localparam int unsigned QueueDepth = 4;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PadByte = 8'h80;

    // One classified beat from the front end.
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_item;

endpackage

/* sv/sha1_front.sv */
// Input queue: accepts beats, drops empty ones, hands them to the core.
module sha1_front #(
    parameter int unsigned DEPTH = sha1_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  sha1_pkg::t_item i_item,
    output logic            o_valid,
    output sha1_pkg::t_item o_item,
    input  logic            i_take
);
    import sha1_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    // Keep only beats that carry a byte or end a message.
    assign w_wr = i_push && !o_full && (i_item.present || i_item.last);
    assign w_rd = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Advance pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

endmodule

/* sv/sha1_core.sv */
// Back end: block buffer, padding, 80-round compression and digest output.
module sha1_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sha1_pkg::t_item i_item,
    output logic            o_take,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [31:0]     o_digest_word,
    output logic [2:0]      o_word_number,
    output logic            o_final_word
);
    import sha1_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PAD  = 6'b000010,
        S_LEN  = 6'b000100,
        S_RND  = 6'b001000,
        S_ADD  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state        r_st, n_st;
    logic [31:0]   r_w [16];
    logic [5:0]    r_fill;
    logic [63:0]   r_bits;
    logic [31:0]   r_h [5];
    logic [31:0]   r_a, r_b, r_c, r_d, r_e;
    logic [6:0]    r_t;
    logic          r_fin;     // message ended; 0x80 still to be written
    logic          r_pad;     // 0x80 written; zero padding and length still owed
    logic          r_dig;     // this compression finishes the digest
    logic [2:0]    r_oidx;
    logic [2:0]    r_lidx;

    logic [7:0]    w_byte;
    logic          w_put;
    logic [31:0]   w_f, w_k, w_tmp, w_wnew;

    // Byte to write into the buffer this cycle.
    always_comb begin
        w_put  = 1'b0;
        w_byte = 8'h00;
        o_take = 1'b0;
        case (r_st)
            S_IDLE: begin
                o_take = i_valid && !r_fin;
                if (i_valid && i_item.present && !r_fin) begin
                    w_put = 1'b1; w_byte = i_item.data;
                end else if (r_fin) begin
                    w_put = 1'b1; w_byte = PadByte;
                end
            end
            S_PAD: begin
                w_put = 1'b1; w_byte = 8'h00;
            end
            S_LEN: begin
                w_put = 1'b1;
                w_byte = r_bits[8*(7-r_lidx) +: 8];
            end
            default: ;
        endcase
    end

    // Round function.
    always_comb begin
        if (r_t < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d); w_k = K0;
        end else if (r_t < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d; w_k = K1;
        end else if (r_t < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d); w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d; w_k = K3;
        end
        w_tmp  = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_w[0];
        w_wnew = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_wnew = {w_wnew[30:0], w_wnew[31]};
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (w_put && r_fill == 6'd63) n_st = S_RND;
                    else if (r_fin) n_st = (r_fill == 6'd55) ? S_LEN : S_PAD;
                    else if (o_take && i_item.last) n_st = S_IDLE;
            S_PAD:  if (r_fill == 6'd63) n_st = S_RND;
                    else if (r_fill == 6'd55) n_st = S_LEN;
            S_LEN:  if (r_lidx == 3'd7) n_st = S_RND;
            S_RND:  if (r_t == 7'd79) n_st = S_ADD;
            S_ADD:  n_st = r_dig ? S_OUT : (r_pad ? S_PAD : S_IDLE);
            S_OUT:  if (i_pop && r_oidx == 3'd4) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // Buffer: shift words as rounds consume the schedule; load bytes in place.
    always_ff @(posedge i_clk) begin
        if (r_st == S_RND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_wnew;
        end else if (w_put) begin
            r_w[r_fill[5:2]][8*(3-r_fill[1:0]) +: 8] <= w_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_fill <= '0;
            r_bits <= '0;
            r_h    <= '{H0, H1, H2, H3, H4};
            r_t    <= '0;
            r_fin  <= 1'b0;
            r_pad  <= 1'b0;
            r_dig  <= 1'b0;
            r_oidx <= '0;
            r_lidx <= '0;
        end else begin
            r_st <= n_st;
            if (w_put) r_fill <= r_fill + 6'd1;
            if (r_st == S_IDLE && o_take && i_item.present)
                r_bits <= r_bits + 64'd8;
            // A taken end of message sets r_fin; 0x80 is then written in IDLE, after any full block is compressed.
            if (r_st == S_IDLE && o_take && i_item.last) r_fin <= 1'b1;
            // Writing 0x80 clears r_fin and marks zero padding and length as still owed.
            if (r_st == S_IDLE && r_fin) begin
                r_fin <= 1'b0;
                r_pad <= 1'b1;
            end
            if (r_st == S_LEN) begin
                r_pad  <= 1'b0;
                r_lidx <= r_lidx + 3'd1;
                if (r_lidx == 3'd7) r_dig <= 1'b1;
            end
            if (n_st == S_RND && r_st != S_RND) begin
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                r_d <= r_h[3]; r_e <= r_h[4];
                r_t <= '0;
            end
            if (r_st == S_RND) begin
                r_e <= r_d; r_d <= r_c; r_c <= {r_b[1:0], r_b[31:2]};
                r_b <= r_a; r_a <= w_tmp;
                r_t <= r_t + 7'd1;
            end
            if (r_st == S_ADD) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
                r_oidx <= '0;
            end
            if (r_st == S_OUT && i_pop) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd4) begin
                    r_h    <= '{H0, H1, H2, H3, H4};
                    r_bits <= '0;
                    r_fill <= '0;
                    r_dig  <= 1'b0;
                    r_lidx <= '0;
                end
            end
        end
    end

    assign o_empty       = (r_st != S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_number = r_oidx;
    assign o_final_word  = (r_oidx == 3'd4);

endmodule

/* sv/sha1_message_hash.sv */
// Top level of the SHA-1 message hash engine.
//   channel | direction | handshake     | beat
//   input   | in        | push / full   | data_byte, byte_present, end_of_message
//   digest  | out       | empty / pop   | digest_word, word_number, final_word
// The core takes a byte beat straight into its block buffer; each full 64-byte block then
// stalls intake for the one-round-per-cycle compression loop and the final add. Padding
// writes one byte per cycle, pausing while a full block is compressed.
// Reset clears the queue, counts and chaining words; the buffer is not cleared.
// The input queue keeps taking beats until full while the core compresses or waits on pop.
module sha1_message_hash #(
    parameter int unsigned QUEUE_DEPTH = sha1_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_final_word
);
    import sha1_pkg::*;

    t_item w_in, w_q;
    logic  w_valid, w_take;

    assign w_in = '{data: i_data_byte, present: i_byte_present, last: i_end_of_message};

    sha1_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_item(w_in),
        .o_valid(w_valid), .o_item(w_q), .i_take(w_take)
    );

    sha1_core u_core (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_item(w_q), .o_take(w_take),
        .o_empty(empty), .i_pop(pop), .o_digest_word, .o_word_number, .o_final_word
    );

endmodule
